### src/lcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types and constants of the letterbox coordinate mapper.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int DIM_BITS_DEF = 12;
    localparam int COORD_W      = 16;
    localparam int REG_IDX_W    = 3;
    localparam int MID_DEPTH    = 4;
    localparam int OUT_DEPTH    = 2;

    localparam int RST_SRC_W = 1024;
    localparam int RST_SRC_H = 600;
    localparam int RST_DST_W = 1024;
    localparam int RST_DST_H = 600;
    localparam int RST_IMG_W = 1024;
    localparam int RST_IMG_H = 600;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SRC_W = 3'd0,
        REG_SRC_H = 3'd1,
        REG_DST_W = 3'd2,
        REG_DST_H = 3'd3,
        REG_IMG_W = 3'd4,
        REG_IMG_H = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic                      mapped;
    } t_out;

endpackage
`default_nettype wire

### src/letterbox_coordinate_mapper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// letterbox_coordinate_mapper_top
// Maps touch points onto a centered letterboxed image and rescales them.
//
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------
// input    | push / full        | i_in  (x_in, y_in)
// result   | pop / empty        | o_out (x_out, y_out, mapped)
// config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while the result queue has room. The back
// pipeline holds two bit-per-stage dividers on each axis. Synchronous
// active-low reset empties both queues and loads the register defaults.
// A full result queue stalls the whole back pipeline; the input queue
// keeps taking words until it fills.
// ----------------------------------------------------------------------------
module letterbox_coordinate_mapper_top #(
    parameter int DIM_BITS = lcm_pkg::DIM_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire lcm_pkg::t_in                  i_in,
    output logic                               empty,
    input  wire logic                          pop,
    output lcm_pkg::t_out                      o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [lcm_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DIM_BITS-1:0]           i_cfg_data
);
    localparam int ENTRY_W = 1 + 2*lcm_pkg::COORD_W + 4*DIM_BITS;
    localparam int OUT_W   = $bits(lcm_pkg::t_out);

    logic [DIM_BITS-1:0] r_src_w;
    logic [DIM_BITS-1:0] r_src_h;
    logic [DIM_BITS-1:0] r_dst_w;
    logic [DIM_BITS-1:0] r_dst_h;
    logic [DIM_BITS-1:0] r_img_w;
    logic [DIM_BITS-1:0] r_img_h;

    logic [ENTRY_W-1:0] front_entry;
    logic [ENTRY_W-1:0] mid_entry;
    logic               mid_empty;
    logic               back_pop;
    logic               back_push;
    logic               out_full;
    lcm_pkg::t_out      back_res;
    logic [OUT_W-1:0]   out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DIM_BITS'(lcm_pkg::RST_SRC_W);
            r_src_h <= DIM_BITS'(lcm_pkg::RST_SRC_H);
            r_dst_w <= DIM_BITS'(lcm_pkg::RST_DST_W);
            r_dst_h <= DIM_BITS'(lcm_pkg::RST_DST_H);
            r_img_w <= DIM_BITS'(lcm_pkg::RST_IMG_W);
            r_img_h <= DIM_BITS'(lcm_pkg::RST_IMG_H);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcm_pkg::REG_SRC_W: r_src_w <= i_cfg_data;
                lcm_pkg::REG_SRC_H: r_src_h <= i_cfg_data;
                lcm_pkg::REG_DST_W: r_dst_w <= i_cfg_data;
                lcm_pkg::REG_DST_H: r_dst_h <= i_cfg_data;
                lcm_pkg::REG_IMG_W: r_img_w <= i_cfg_data;
                lcm_pkg::REG_IMG_H: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lcm_front #(.DIM_BITS(DIM_BITS), .ENTRY_W(ENTRY_W)) u_front (
        .i_in    (i_in),
        .i_src_w (r_src_w),
        .i_src_h (r_src_h),
        .i_img_w (r_img_w),
        .i_img_h (r_img_h),
        .o_entry (front_entry)
    );

    lcm_fifo #(.WIDTH(ENTRY_W), .DEPTH(lcm_pkg::MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .i_pop   (back_pop),
        .o_data  (mid_entry),
        .o_full  (full),
        .o_empty (mid_empty)
    );

    lcm_back #(.DIM_BITS(DIM_BITS), .ENTRY_W(ENTRY_W)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (mid_entry),
        .i_entry_vld (!mid_empty),
        .o_pop       (back_pop),
        .i_src_w     (r_src_w),
        .i_src_h     (r_src_h),
        .i_dst_w     (r_dst_w),
        .i_dst_h     (r_dst_h),
        .i_img_w     (r_img_w),
        .i_img_h     (r_img_h),
        .i_out_full  (out_full),
        .o_push      (back_push),
        .o_res       (back_res)
    );

    lcm_fifo #(.WIDTH(OUT_W), .DEPTH(lcm_pkg::OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign o_out = lcm_pkg::t_out'(out_data);

endmodule
`default_nettype wire

### src/lcm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_fifo
// Small register queue; depth must be a power of two.
// ----------------------------------------------------------------------------
module lcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

### src/lcm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_front
// Classifies a point as mapped or pass-through, clamps each axis to the
// source range and forms the first scaling product.
// ----------------------------------------------------------------------------
module lcm_front #(
    parameter int DIM_BITS = lcm_pkg::DIM_BITS_DEF,
    parameter int ENTRY_W  = 1 + 2*lcm_pkg::COORD_W + 4*DIM_BITS
) (
    input  wire lcm_pkg::t_in        i_in,
    input  wire logic [DIM_BITS-1:0] i_src_w,
    input  wire logic [DIM_BITS-1:0] i_src_h,
    input  wire logic [DIM_BITS-1:0] i_img_w,
    input  wire logic [DIM_BITS-1:0] i_img_h,
    output logic      [ENTRY_W-1:0]  o_entry
);
    localparam int CW = lcm_pkg::COORD_W;

    logic                mapped;
    logic [DIM_BITS-1:0] cx;
    logic [DIM_BITS-1:0] cy;
    logic [2*DIM_BITS-1:0] px;
    logic [2*DIM_BITS-1:0] py;

    function automatic logic [DIM_BITS-1:0] clamp_axis(
        input logic signed [CW-1:0] c,
        input logic [DIM_BITS-1:0]  s
    );
        logic [CW-2:0] cu;
        logic [CW-2:0] su;
        cu = c[CW-2:0];
        su = (CW-1)'(s);
        if (c[CW-1]) begin
            return '0;
        end else if (cu > su) begin
            return s;
        end else begin
            return cu[DIM_BITS-1:0];
        end
    endfunction

    assign mapped = (i_img_w != '0) && (i_img_h != '0);
    assign cx     = clamp_axis(i_in.x_in, i_src_w);
    assign cy     = clamp_axis(i_in.y_in, i_src_h);
    assign px     = (2*DIM_BITS)'(cx) * (2*DIM_BITS)'(i_img_w);
    assign py     = (2*DIM_BITS)'(cy) * (2*DIM_BITS)'(i_img_h);
    assign o_entry = {mapped, i_in.x_in, i_in.y_in, px, py};

endmodule
`default_nettype wire

### src/lcm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lcm_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo
);
    logic [DEN_W:0]   r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0]   rem_i;
        logic [NUM_W-1:0] nq_i;
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W+1:0] diff;
        logic             qb;

        if (k == 0) begin : g_first
            assign rem_i = '0;
            assign nq_i  = i_num;
        end else begin : g_next
            assign rem_i = r_rem[k-1];
            assign nq_i  = r_nq[k-1];
        end

        assign rem_sh = {rem_i[DEN_W-1:0], nq_i[NUM_W-1]};
        assign diff   = {1'b0, rem_sh} - {2'b00, i_den};
        assign qb     = !diff[DEN_W+1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= qb ? diff[DEN_W:0] : rem_sh;
                r_nq[k]  <= {nq_i[NUM_W-2:0], qb};
            end
        end
    end

    assign o_quo = r_nq[NUM_W-1];

endmodule
`default_nettype wire

### src/lcm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_back
// Per-axis scale division, centering offset, rescale multiply, rescale
// division and final clamp; stalls as a whole on a full result queue.
// ----------------------------------------------------------------------------
module lcm_back #(
    parameter int DIM_BITS = lcm_pkg::DIM_BITS_DEF,
    parameter int ENTRY_W  = 1 + 2*lcm_pkg::COORD_W + 4*DIM_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [ENTRY_W-1:0]  i_entry,
    input  wire logic                i_entry_vld,
    output logic                     o_pop,
    input  wire logic [DIM_BITS-1:0] i_src_w,
    input  wire logic [DIM_BITS-1:0] i_src_h,
    input  wire logic [DIM_BITS-1:0] i_dst_w,
    input  wire logic [DIM_BITS-1:0] i_dst_h,
    input  wire logic [DIM_BITS-1:0] i_img_w,
    input  wire logic [DIM_BITS-1:0] i_img_h,
    input  wire logic                i_out_full,
    output logic                     o_push,
    output lcm_pkg::t_out            o_res
);
    localparam int B  = DIM_BITS;
    localparam int CW = lcm_pkg::COORD_W;
    localparam int N1 = 2*B;
    localparam int N2 = 2*B + 1;

    typedef struct packed {
        logic          mapped;
        logic [CW-1:0] rx;
        logic [CW-1:0] ry;
        logic [1:0]    zero;
    } t_side;

    logic          en;
    logic [B-1:0]  s   [2];
    logic [B-1:0]  d   [2];
    logic [B-1:0]  im  [2];
    logic [N1-1:0] p   [2];
    logic [N1-1:0] q1  [2];
    logic [N2-1:0] q2  [2];
    logic [CW-1:0] res [2];
    logic          zero_a [2];
    t_side         side_in;

    logic          r_v1 [N1];
    t_side         r_s1 [N1];
    logic          r_va;
    t_side         r_sa;
    logic [B:0]    r_mag [2];
    logic          r_vb;
    t_side         r_sb;
    logic [N2-1:0] r_prod [2];
    logic          r_v2 [N2];
    t_side         r_s2 [N2];

    assign en    = !i_out_full;
    assign o_pop = en && i_entry_vld;

    assign s[0]  = i_src_w;
    assign s[1]  = i_src_h;
    assign d[0]  = i_dst_w;
    assign d[1]  = i_dst_h;
    assign im[0] = i_img_w;
    assign im[1] = i_img_h;
    assign p[0]  = i_entry[2*N1-1:N1];
    assign p[1]  = i_entry[N1-1:0];

    assign side_in.mapped = i_entry[ENTRY_W-1];
    assign side_in.rx     = i_entry[ENTRY_W-2 -: CW];
    assign side_in.ry     = i_entry[ENTRY_W-2-CW -: CW];
    assign side_in.zero   = '0;

    // sideband line matching the first divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N1; k++) begin
                r_v1[k] <= 1'b0;
            end
        end else if (en) begin
            r_v1[0] <= o_pop;
            for (int k = 1; k < N1; k++) begin
                r_v1[k] <= r_v1[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= side_in;
            for (int k = 1; k < N1; k++) begin
                r_s1[k] <= r_s1[k-1];
            end
        end
    end

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic signed [B:0]   diff;
        logic signed [B:0]   off;
        logic signed [B+1:0] t;

        lcm_div #(.NUM_W(N1), .DEN_W(B)) u_div1 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (p[a]),
            .i_den (s[a]),
            .o_quo (q1[a])
        );

        // centering offset, truncated toward zero
        assign diff = $signed({1'b0, s[a]}) - $signed({1'b0, im[a]});
        assign off  = (diff + $signed((B+1)'(diff[B]))) >>> 1;
        assign t    = $signed({2'b00, q1[a][B-1:0]}) + (B+2)'(off);

        // a sum at or below zero rescales to zero
        assign zero_a[a] = t[B+1] || (t == '0);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mag[a]  <= t[B:0];
                r_prod[a] <= N2'(r_mag[a]) * N2'(d[a]);
            end
        end

        lcm_div #(.NUM_W(N2), .DEN_W(B)) u_div2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_prod[a]),
            .i_den (s[a]),
            .o_quo (q2[a])
        );

        always_comb begin
            if (r_s2[N2-1].zero[a] || (s[a] == '0)) begin
                res[a] = '0;
            end else if (q2[a] > N2'(d[a])) begin
                res[a] = CW'(d[a]);
            end else begin
                res[a] = CW'(q2[a][B-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (en) begin
            r_va <= r_v1[N1-1];
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa.mapped <= r_s1[N1-1].mapped;
            r_sa.rx     <= r_s1[N1-1].rx;
            r_sa.ry     <= r_s1[N1-1].ry;
            r_sa.zero   <= {zero_a[1], zero_a[0]};
            r_sb        <= r_sa;
        end
    end

    // sideband line matching the second divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N2; k++) begin
                r_v2[k] <= 1'b0;
            end
        end else if (en) begin
            r_v2[0] <= r_vb;
            for (int k = 1; k < N2; k++) begin
                r_v2[k] <= r_v2[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2[0] <= r_sb;
            for (int k = 1; k < N2; k++) begin
                r_s2[k] <= r_s2[k-1];
            end
        end
    end

    assign o_push = en && r_v2[N2-1];

    always_comb begin
        o_res.mapped = r_s2[N2-1].mapped;
        if (r_s2[N2-1].mapped) begin
            o_res.x_out = res[0];
            o_res.y_out = res[1];
        end else begin
            o_res.x_out = r_s2[N2-1].rx;
            o_res.y_out = r_s2[N2-1].ry;
        end
    end

endmodule
`default_nettype wire

### src/lcm_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_chk
// Port-level checks of the coordinate mapper, bound to the top level.
// ----------------------------------------------------------------------------
module lcm_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          full,
    input wire logic          empty,
    input wire logic          pop,
    input wire lcm_pkg::t_out o_out
);
    localparam int CW = lcm_pkg::COORD_W;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result word lost");

    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_out))
        else $error("waiting result word changed");

    // mapped coordinates are clamped at zero
    a_mapped_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out.mapped |-> !o_out.x_out[CW-1] && !o_out.y_out[CW-1])
        else $error("mapped coordinate negative");

endmodule

bind letterbox_coordinate_mapper_top lcm_chk u_chk (.*);
`default_nettype wire

### dv/letterbox_coordinate_mapper_top_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// letterbox_coordinate_mapper_top_test
// Self-checking bench for the letterbox coordinate mapper. Directed points
// and random points go through several register settings; every result word
// is compared per field with its table row or a behavioral bench mapper.
// ----------------------------------------------------------------------------
module letterbox_coordinate_mapper_top_test;

    localparam int DB      = 12;
    localparam int LAT     = 4 * DB + 4;
    localparam int N_RAND  = 1600;
    localparam int N_PHASE = 8;
    localparam int LONG_HOLD = 300;
    localparam longint CYCLE_LIMIT = 400000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    lcm_pkg::t_in                  i_in = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    lcm_pkg::t_out                 o_out;
    logic                          i_cfg_we = 1'b0;
    logic [lcm_pkg::REG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DB-1:0]                 i_cfg_data = '0;

    letterbox_coordinate_mapper_top #(.DIM_BITS(DB)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench copy of the registers
    logic [DB-1:0] dims [6];
    lcm_pkg::t_out mapped_q [$];
    int            fails = 0;
    longint        cycles = 0;
    bit            idle_ok = 1'b1;
    int            hold_rx = 0;
    bit            long_go = 1'b0;
    bit            long_done = 1'b0;
    int            long_cnt = 0;

    function automatic longint div0(longint n, longint d);
        if (d == 0) return 0;
        return n / d;
    endfunction

    function automatic logic [15:0] map_axis(longint c, longint s, longint d, longint im);
        longint off, t;
        off = div0(s - im, 2);
        if (c < 0) c = 0;
        else if (c > s) c = s;
        t = div0(c * im, s) + off;
        t = div0(t * d, s);
        if (t < 0) t = 0;
        else if (t > d) t = d;
        return t[15:0];
    endfunction

    function automatic lcm_pkg::t_out map_point(lcm_pkg::t_in p);
        lcm_pkg::t_out r;
        if (dims[lcm_pkg::REG_IMG_W] == 0 || dims[lcm_pkg::REG_IMG_H] == 0) begin
            r.x_out = p.x_in;
            r.y_out = p.y_in;
            r.mapped = 1'b0;
        end else begin
            r.x_out = map_axis(longint'(p.x_in), dims[lcm_pkg::REG_SRC_W],
                               dims[lcm_pkg::REG_DST_W], dims[lcm_pkg::REG_IMG_W]);
            r.y_out = map_axis(longint'(p.y_in), dims[lcm_pkg::REG_SRC_H],
                               dims[lcm_pkg::REG_DST_H], dims[lcm_pkg::REG_IMG_H]);
            r.mapped = 1'b1;
        end
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        fails++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (long_go && !long_done) begin
            if (long_cnt >= LONG_HOLD) begin
                long_done <= 1'b1;
            end else begin
                long_cnt <= long_cnt + 1;
            end
        end
    end

    // result side: check accepted words, random pop bursts, long hold-offs
    always @(posedge i_clk) begin
        lcm_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (mapped_q.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                want = mapped_q.pop_front();
                if (o_out.x_out !== want.x_out) report("x_out", o_out.x_out, want.x_out);
                if (o_out.y_out !== want.y_out) report("y_out", o_out.y_out, want.y_out);
                if (o_out.mapped !== want.mapped) report("mapped", o_out.mapped, want.mapped);
            end
        end
        if (long_go && !long_done) begin
            pop <= 1'b0;
        end else if (hold_rx > 0) begin
            hold_rx <= hold_rx - 1;
            pop <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            hold_rx <= $urandom_range(0, 5);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_point(lcm_pkg::t_in p, bit with_want, lcm_pkg::t_out want);
        lcm_pkg::t_out pred;
        int gap;
        if (idle_ok && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pred = map_point(p);
        if (with_want && pred !== want)
            $display("note: table row disagrees with bench mapper");
        mapped_q.push_back(with_want ? want : pred);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (mapped_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_dim(lcm_pkg::t_reg_idx idx, logic [DB-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dims[idx] = v;
    endtask

    function automatic logic [15:0] rand_coord(int lim);
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'h8000 | 16'($urandom_range(0, 3));
            2: return 16'h7fff - 16'($urandom_range(0, 3));
            3: return 16'(lim);
            default: return 16'($urandom_range(0, lim + 2));
        endcase
    endfunction

    function automatic logic [DB-1:0] rand_dim(int lo);
        case ($urandom_range(0, 5))
            0: return DB'(lo);
            1: return '1;
            2: return DB'($urandom);
            default: return DB'($urandom_range(lo, 2048));
        endcase
    endfunction

    typedef struct {
        logic [15:0]   x;
        logic [15:0]   y;
        bit            has_want;
        lcm_pkg::t_out want;
    } t_row;

    // defaults: identity mapping up to clamping
    t_row dir_rows [] = '{
        '{16'd0,    16'd0,    1, '{16'd0, 16'd0, 1'b1}},
        '{16'd1024, 16'd600,  1, '{16'd1024, 16'd600, 1'b1}},
        '{16'h7fff, 16'h7fff, 1, '{16'd1024, 16'd600, 1'b1}},
        '{16'h8000, 16'h8000, 1, '{16'd0, 16'd0, 1'b1}},
        '{16'hffff, 16'd1,    1, '{16'd0, 16'd1, 1'b1}},
        '{16'd512,  16'd300,  0, '{16'd0, 16'd0, 1'b0}},
        '{16'h5555, 16'haaaa, 1, '{16'd1024, 16'd0, 1'b1}},
        '{16'd1023, 16'd599,  0, '{16'd0, 16'd0, 1'b0}}
    };

    initial begin
        lcm_pkg::t_in  p;
        lcm_pkg::t_out none;
        int            n_ph;
        none = '0;
        dims[lcm_pkg::REG_SRC_W] = DB'(lcm_pkg::RST_SRC_W);
        dims[lcm_pkg::REG_SRC_H] = DB'(lcm_pkg::RST_SRC_H);
        dims[lcm_pkg::REG_DST_W] = DB'(lcm_pkg::RST_DST_W);
        dims[lcm_pkg::REG_DST_H] = DB'(lcm_pkg::RST_DST_H);
        dims[lcm_pkg::REG_IMG_W] = DB'(lcm_pkg::RST_IMG_W);
        dims[lcm_pkg::REG_IMG_H] = DB'(lcm_pkg::RST_IMG_H);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            p.x_in = dir_rows[k].x;
            p.y_in = dir_rows[k].y;
            send_point(p, dir_rows[k].has_want, dir_rows[k].want);
        end
        drain();

        // mapping disabled: pass-through with flag clear
        write_dim(lcm_pkg::REG_IMG_W, '0);
        p = '{16'h8000, 16'h7fff};
        send_point(p, 1, '{16'h8000, 16'h7fff, 1'b0});
        p = '{16'hffff, 16'd0};
        send_point(p, 1, '{16'hffff, 16'd0, 1'b0});
        drain();
        write_dim(lcm_pkg::REG_IMG_W, 12'd1024);
        write_dim(lcm_pkg::REG_IMG_H, '0);
        p = '{16'd5, 16'h8001};
        send_point(p, 1, '{16'd5, 16'h8001, 1'b0});
        drain();
        // image larger than source, zero source, full-scale target
        write_dim(lcm_pkg::REG_IMG_H, 12'hfff);
        write_dim(lcm_pkg::REG_SRC_H, 12'd1);
        write_dim(lcm_pkg::REG_DST_H, 12'hfff);
        write_dim(lcm_pkg::REG_SRC_W, 12'd0);
        write_dim(lcm_pkg::REG_DST_W, 12'd0);
        p = '{16'd100, 16'd1};
        send_point(p, 1, '{16'd0, 16'd4095, 1'b1});
        p = '{16'h7fff, 16'd0};
        send_point(p, 0, none);
        drain();
        write_dim(lcm_pkg::REG_SRC_W, 12'hfff);
        write_dim(lcm_pkg::REG_DST_W, 12'hfff);
        write_dim(lcm_pkg::REG_IMG_W, 12'd1);
        p = '{16'd4095, 16'h8000};
        send_point(p, 0, none);
        p = '{16'd2048, 16'd1};
        send_point(p, 0, none);
        drain();

        // random phases, each with fresh registers
        for (int ph = 0; ph < N_PHASE; ph++) begin
            write_dim(lcm_pkg::REG_SRC_W, ph == 0 ? 12'hfff : rand_dim(ph == 1 ? 0 : 1));
            write_dim(lcm_pkg::REG_SRC_H, ph == 0 ? 12'd1 : rand_dim(1));
            write_dim(lcm_pkg::REG_DST_W, ph == 0 ? 12'd0 : rand_dim(0));
            write_dim(lcm_pkg::REG_DST_H, ph == 0 ? 12'hfff : rand_dim(0));
            write_dim(lcm_pkg::REG_IMG_W, ph == 2 ? 12'd0 : rand_dim(1));
            write_dim(lcm_pkg::REG_IMG_H, ph == 0 ? 12'hfff : rand_dim(1));
            if (ph == N_PHASE - 1) idle_ok = 1'b0;
            if (ph == 3) long_go = 1'b1;
            n_ph = N_RAND / N_PHASE;
            for (int k = 0; k < n_ph; k++) begin
                p.x_in = rand_coord(dims[lcm_pkg::REG_SRC_W]);
                p.y_in = rand_coord(dims[lcm_pkg::REG_SRC_H]);
                send_point(p, 0, none);
            end
            drain();
        end

        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
src/lcm_pkg.sv
src/lcm_fifo.sv
src/lcm_front.sv
src/lcm_div.sv
src/lcm_back.sv
src/letterbox_coordinate_mapper_top.sv
src/lcm_chk.sv
dv/letterbox_coordinate_mapper_top_test.sv
